### hdl/tct_pkg.sv
// Package for the triangle corner tangent block: widths and fixed-point
// constants. No dependencies.
`timescale 1ns / 1ps
package tct_pkg;
   localparam int EpsWidth   = 36;
   localparam int PosWidth   = 32;
   localparam int TexWidth   = 18;
   localparam logic [35:0] EpsReset = 36'd4295;
   localparam logic [31:0] OneQ16   = 32'h0001_0000;
   localparam logic [31:0] SatPos   = 32'h7FFF_FFFF;
   localparam logic [31:0] SatNeg   = 32'h8000_0000;
endpackage

### hdl/triangle_corner_tangent.sv
// Top level of the triangle corner tangent block.
// Uses tct_pkg and tct_div.
`timescale 1ns / 1ps
// Usage:
//  Send one vertex per req_ transfer: tdata holds pos_x, pos_y, pos_z,
//  tex_u, tex_v from the lowest bit up. The first two vertices are held;
//  the third starts the calculation of three corners, each leaving as one
//  rsp_ transfer (tuser carries degenerate then last_corner, tdata carries
//  corner then the six vector components).
//  Each corner is worked out by a sequencer that drives one shared
//  multiplier (one product per cycle) and one bit-serial divider (69
//  steps per quotient). For each quotient it forms the edge differences
//  and the two numerator products, then waits in the divide state. A
//  corner passes through the UV differences and determinant, six
//  quotients and the output register; a degenerate corner skips the
//  quotients. req_tready stays low from the third vertex transfer until
//  the last corner of the triangle has left.
//  A stalled receiver holds the pending corner in the output register and
//  the sequencer waits for the transfer before the next corner.
//  Reset clears the vertex count and the sequencer and loads det_epsilon
//  with its reset value; write csr_ only while no triangle is in work.
module triangle_corner_tangent #(
   parameter int EpsW = tct_pkg::EpsWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [EpsW-1:0]  csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [135:0]     req_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v, pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [199:0]     rsp_tdata,  // corner, tan x/y/z, bitan x/y/z, pad
   output logic [1:0]       rsp_tuser   // degenerate, last_corner
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DIFF = 6'b000010, S_DET = 6'b000100,
      S_MUL  = 6'b001000, S_DIV  = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [EpsW-1:0] eps_ff;
   logic [31:0] pos_ff [9];
   logic [17:0] tex_ff [6];
   logic [1:0]  vcnt_ff;
   logic [1:0]  k_ff;         // corner
   logic [2:0]  step_ff;      // multiply step / component
   logic [2:0]  comp_ff;      // quotient index 0..5
   logic signed [18:0] du0_ff, dv0_ff, du1_ff, dv1_ff;
   logic signed [36:0] det_ff, p_ff;
   logic signed [52:0] num_ff;
   logic signed [32:0] e0_ff, e1_ff;
   logic [31:0] res_ff [6];
   logic        degen_ff;
   logic        dstart_ff;
   logic [6:0]  wait_ff;
   logic [31:0] quot;

   logic [1:0] pi, qi;
   assign pi = (k_ff == 2'd0) ? 2'd1 : 2'd0;
   assign qi = (k_ff == 2'd2) ? 2'd1 : 2'd2;

   // first position slot of the vertex being written
   logic [3:0] vb;
   assign vb = 4'(vcnt_ff) * 4'd3;

   // shared multiplier: 19 x 33 signed
   logic signed [18:0] ma;
   logic signed [32:0] mb;
   logic signed [51:0] mp;
   assign mp = ma * mb;
   always_comb begin
      ma = '0; mb = '0;
      unique case (step_ff)
         3'd0: begin ma = du0_ff; mb = 33'(dv1_ff); end
         3'd1: begin ma = dv0_ff; mb = 33'(du1_ff); end
         3'd2: begin ma = comp_ff < 3'd3 ? dv1_ff : du0_ff;
                     mb = comp_ff < 3'd3 ? e0_ff : e1_ff; end
         3'd3: begin ma = comp_ff < 3'd3 ? dv0_ff : du1_ff;
                     mb = comp_ff < 3'd3 ? e1_ff : e0_ff; end
         default: ;
      endcase
   end

   logic [1:0] cc;
   assign cc = (comp_ff < 3'd3) ? comp_ff[1:0] : 2'(comp_ff - 3'd3);
   logic [3:0] ik, ip, iq;
   always_comb begin
      ik = 4'(k_ff) * 4'd3 + 4'(cc);
      ip = 4'(pi) * 4'd3 + 4'(cc);
      iq = 4'(qi) * 4'd3 + 4'(cc);
   end

   // |det| stays below 2^36: a UV triangle inside the Q2.16 square
   logic [35:0] adet;
   assign adet = det_ff[36] ? 36'(-det_ff) : 36'(det_ff);

   tct_div u_div (
      .clock(clock), .reset(reset), .start(dstart_ff), .num(num_ff),
      .den(det_ff), .quot(quot)
   );

   logic take_in, out_go;
   assign req_tready = (state_ff == S_IDLE);
   assign take_in = req_tvalid && req_tready;
   assign out_go = rsp_tvalid && rsp_tready;

   // start the divider once the second numerator product is in
   always_ff @(posedge clock) begin
      if (reset) dstart_ff <= 1'b0;
      else       dstart_ff <= (state_ff == S_MUL) && (step_ff == 3'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vcnt_ff <= '0; eps_ff <= EpsW'(tct_pkg::EpsReset);
         rsp_tvalid <= 1'b0;
      end else begin
         if (csr_we) eps_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (take_in) begin
               // store vertex; the third one starts corner 0
               pos_ff[vb]              <= req_tdata[31:0];
               pos_ff[vb + 4'd1]       <= req_tdata[63:32];
               pos_ff[vb + 4'd2]       <= req_tdata[95:64];
               tex_ff[{vcnt_ff, 1'b0}] <= req_tdata[113:96];
               tex_ff[{vcnt_ff, 1'b1}] <= req_tdata[131:114];
               if (vcnt_ff >= 2'd2) begin
                  vcnt_ff <= '0; k_ff <= '0; state_ff <= S_DIFF;
               end else vcnt_ff <= vcnt_ff + 2'd1;
            end
            S_DIFF: begin
               du0_ff <= 19'(signed'(tex_ff[{pi, 1'b0}]))
                         - 19'(signed'(tex_ff[{k_ff, 1'b0}]));
               dv0_ff <= 19'(signed'(tex_ff[{pi, 1'b1}]))
                         - 19'(signed'(tex_ff[{k_ff, 1'b1}]));
               du1_ff <= 19'(signed'(tex_ff[{qi, 1'b0}]))
                         - 19'(signed'(tex_ff[{k_ff, 1'b0}]));
               dv1_ff <= 19'(signed'(tex_ff[{qi, 1'b1}]))
                         - 19'(signed'(tex_ff[{k_ff, 1'b1}]));
               step_ff <= 3'd0; comp_ff <= '0; state_ff <= S_DET;
            end
            S_DET: begin
               if (step_ff == 3'd0) begin
                  p_ff <= 37'(mp); step_ff <= 3'd1;
               end else if (step_ff == 3'd1) begin
                  det_ff <= p_ff - 37'(mp); step_ff <= 3'd4;
               end else begin
                  if (det_ff == '0 || adet < eps_ff) begin
                     degen_ff <= 1'b1;
                     res_ff[0] <= tct_pkg::OneQ16; res_ff[1] <= '0; res_ff[2] <= '0;
                     res_ff[3] <= '0; res_ff[4] <= tct_pkg::OneQ16; res_ff[5] <= '0;
                     state_ff <= S_OUT; rsp_tvalid <= 1'b1;
                  end else begin
                     degen_ff <= 1'b0; step_ff <= 3'd5; state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               if (step_ff == 3'd5) begin
                  e0_ff <= 33'(signed'(pos_ff[ip])) - 33'(signed'(pos_ff[ik]));
                  e1_ff <= 33'(signed'(pos_ff[iq])) - 33'(signed'(pos_ff[ik]));
                  step_ff <= 3'd2;
               end else if (step_ff == 3'd2) begin
                  num_ff <= 53'(mp); step_ff <= 3'd3;
               end else begin
                  num_ff <= num_ff - 53'(mp);
                  wait_ff <= 7'd71; state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (wait_ff == '0) begin
                  res_ff[comp_ff] <= quot;
                  if (comp_ff == 3'd5) begin
                     state_ff <= S_OUT; rsp_tvalid <= 1'b1;
                  end else begin
                     comp_ff <= comp_ff + 3'd1; step_ff <= 3'd5; state_ff <= S_MUL;
                  end
               end else wait_ff <= wait_ff - 7'd1;
            end
            S_OUT: if (out_go) begin
               rsp_tvalid <= 1'b0;
               if (k_ff == 2'd2) state_ff <= S_IDLE;
               else begin k_ff <= k_ff + 2'd1; state_ff <= S_DIFF; end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {6'd0, res_ff[5], res_ff[4], res_ff[3], res_ff[2], res_ff[1],
                       res_ff[0], k_ff};
   assign rsp_tuser = {(k_ff == 2'd2), degen_ff};
endmodule

### hdl/tct_div.sv
// Iterative signed divider: Q16.16 quotient of num/den, truncated toward
// zero and saturated. One quotient bit per cycle. Uses tct_pkg.
`timescale 1ns / 1ps
module tct_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [52:0] num,
   input  logic signed [36:0] den,
   output logic [31:0]        quot
);
   // shift-subtract over 16 fraction + 53 bits: run 69 steps on |num|<<16
   logic [68:0] rem_ff, rem_in;     // dividend shifting out
   logic [36:0] part_ff, part_in;   // partial remainder
   logic [68:0] q_ff, q_in;
   logic [36:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [37:0] trial;
   logic [52:0] an;
   logic [36:0] ad;

   always_comb begin
      an = num[52] ? 53'(-num) : 53'(num);
      ad = den[36] ? 37'(-den) : 37'(den);
      trial = {part_ff, rem_ff[68]} - {1'b0, d_ff};
      rem_in = rem_ff; part_in = part_ff; q_in = q_ff; d_in = d_ff;
      neg_in = neg_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         rem_in = {an, 16'd0};
         part_in = '0; q_in = '0; d_in = ad;
         neg_in = num[52] ^ den[36];
         cnt_in = 7'd69; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = {rem_ff[67:0], 1'b0};
         if (!trial[37]) begin
            part_in = trial[36:0];
            q_in = {q_ff[67:0], 1'b1};
         end else begin
            part_in = {part_ff[35:0], rem_ff[68]};
            q_in = {q_ff[67:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; part_ff <= part_in; q_ff <= q_in;
      d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   logic big;
   always_comb begin
      big = |q_ff[68:32];
      if (neg_ff) begin
         if (big || q_ff[31:0] > tct_pkg::SatNeg) quot = tct_pkg::SatNeg;
         else quot = 32'(-q_ff[31:0]);
      end else begin
         if (big || q_ff[31]) quot = tct_pkg::SatPos;
         else quot = q_ff[31:0];
      end
   end
endmodule

### tb/triangle_corner_tangent_tb.sv
// Self-checking bench for triangle_corner_tangent: drives vertex transfers,
// predicts per-corner tangent/bitangent and compares every rsp_ transfer.
// Depends on tct_pkg and the triangle_corner_tangent RTL only.
`timescale 1ns / 1ps
module triangle_corner_tangent_tb;
   typedef struct packed {
      logic signed [31:0] px, py, pz;
      logic signed [17:0] tu, tv;
   } vertex_type;

   typedef struct packed {
      logic [1:0]   corner;
      logic [31:0]  tx, ty, tz, bx, by, bz;
      logic         degen, last;
   } corner_type;

   // directed row: vertex, optional hand-typed expectation for its corners
   typedef struct {
      vertex_type   vtx;
      logic         typed;
      corner_type   hand[3];
   } row_type;

   localparam int ItemCount = 200;
   localparam int LimitCyc  = 900000;
   localparam int DrainCyc  = 1600;
   localparam int HoldCyc   = 6000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [35:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   triangle_corner_tangent DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [35:0]        eps_q;
   logic signed [63:0] pos_held[9];
   logic signed [63:0] tex_held[6];
   int                 vert_count;
   corner_type         pending_corners[$];

   int    errors = 0;
   int    cycles = 0;
   int    rx_idle = 0;       // receiver idle cycles left in this burst
   bit    calm = 0;          // last part of the run: no idling
   bit    hold_off = 0;      // receiver long stall in progress
   bit    hold_go = 0;       // ask for the long stall

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   // Q16.16 of num/den, truncated toward zero, saturated
   function automatic logic [31:0] quotient_q16(input logic signed [63:0] num,
                                                input logic signed [63:0] den);
      logic [63:0] n, d, qi, rem, q;
      bit neg;
      n   = num < 0 ? -num : num;
      d   = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      qi  = n / d;
      rem = n % d;
      if (qi >= 64'd65536) q = 64'h1_0000_0000;
      else begin
         q = qi;
         for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d) begin
               rem = rem - d;
               q[0] = 1'b1;
            end
         end
      end
      if (neg) begin
         if (q > 64'h8000_0000) q = 64'h8000_0000;
         return 32'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic corner_type tangent_of_corner(input int k);
      corner_type r;
      int p, q;
      logic signed [63:0] du0, dv0, du1, dv1, det, e0, e1, adet;
      logic [31:0] tv[3], bv[3];
      p = (k == 0) ? 1 : 0;
      q = (k == 2) ? 1 : 2;
      du0 = tex_held[p*2] - tex_held[k*2];
      dv0 = tex_held[p*2+1] - tex_held[k*2+1];
      du1 = tex_held[q*2] - tex_held[k*2];
      dv1 = tex_held[q*2+1] - tex_held[k*2+1];
      det = du0 * dv1 - dv0 * du1;
      adet = det < 0 ? -det : det;
      r.corner = 2'(k);
      r.last = (k == 2);
      if (det == 0 || adet < $signed({28'd0, eps_q})) begin
         r.tx = tct_pkg::OneQ16; r.ty = '0; r.tz = '0;
         r.bx = '0; r.by = tct_pkg::OneQ16; r.bz = '0;
         r.degen = 1'b1;
      end else begin
         for (int c = 0; c < 3; c++) begin
            e0 = pos_held[p*3+c] - pos_held[k*3+c];
            e1 = pos_held[q*3+c] - pos_held[k*3+c];
            tv[c] = quotient_q16(dv1 * e0 - dv0 * e1, det);
            bv[c] = quotient_q16(du0 * e1 - du1 * e0, det);
         end
         {r.tx, r.ty, r.tz} = {tv[0], tv[1], tv[2]};
         {r.bx, r.by, r.bz} = {bv[0], bv[1], bv[2]};
         r.degen = 1'b0;
      end
      return r;
   endfunction

   // absorb one accepted vertex; on the third, queue three corners
   task automatic absorb_vertex(input vertex_type v);
      int s;
      s = vert_count > 2 ? 2 : vert_count;
      pos_held[s*3] = v.px; pos_held[s*3+1] = v.py; pos_held[s*3+2] = v.pz;
      tex_held[s*2] = v.tu; tex_held[s*2+1] = v.tv;
      if (s < 2) vert_count = s + 1;
      else begin
         vert_count = 0;
         for (int k = 0; k < 3; k++)
            pending_corners.insert(pending_corners.size(), tangent_of_corner(k));
      end
   endtask

   // sender: optional idle burst, then offer one vertex and hold until transfer
   task automatic send_vertex(input vertex_type v);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, v.tv, v.tu, v.pz, v.py, v.px};
      do @(posedge clock); while (!req_tready);
      absorb_vertex(v);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_corners.size() != 0) @(posedge clock);
      repeat (DrainCyc) @(posedge clock);
   endtask

   task automatic write_epsilon(input logic [35:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      eps_q = value;
   endtask

   function automatic vertex_type random_vertex();
      vertex_type v;
      int mode;
      mode = $urandom_range(0, 9);
      v.px = $urandom; v.py = $urandom; v.pz = $urandom;
      v.tu = 18'($urandom); v.tv = 18'($urandom);
      if (mode < 6) begin
         // modest geometry keeps most quotients in range
         v.px = $signed(32'($urandom_range(0, 32'h7_FFFF))) - 32'sh4_0000;
         v.py = $signed(32'($urandom_range(0, 32'h7_FFFF))) - 32'sh4_0000;
         v.pz = $signed(32'($urandom_range(0, 32'h7_FFFF))) - 32'sh4_0000;
      end
      if (mode == 9) begin
         v.tu = 18'($urandom_range(0, 3)); v.tv = 18'($urandom_range(0, 3));
      end
      return v;
   endfunction

   // receiver: random idle bursts, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_idle = 0;
      end else if (hold_off) rsp_tready <= 1'b0;
      else if (calm) rsp_tready <= 1'b1;
      else begin
         if (rx_idle == 0 && rsp_tready && $urandom_range(0, 3) == 0)
            rx_idle = $urandom_range(1, 3);
         if (rx_idle > 0) begin
            rsp_tready <= 1'b0;
            rx_idle--;
         end else rsp_tready <= 1'b1;
      end
   end

   // checker: compare each rsp_ transfer with the oldest predicted corner
   always @(posedge clock) begin
      corner_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.corner = rsp_tdata[1:0];
         {got.bz, got.by, got.bx, got.tz, got.ty, got.tx} = rsp_tdata[193:2];
         got.degen = rsp_tuser[0];
         got.last = rsp_tuser[1];
         if (pending_corners.size() == 0) report("unexpected corner", got.corner, 0);
         else begin
            want = pending_corners.pop_front();
            if (got.corner != want.corner) report("corner", got.corner, want.corner);
            if (got.tx != want.tx) report("tangent_x", got.tx, want.tx);
            if (got.ty != want.ty) report("tangent_y", got.ty, want.ty);
            if (got.tz != want.tz) report("tangent_z", got.tz, want.tz);
            if (got.bx != want.bx) report("bitangent_x", got.bx, want.bx);
            if (got.by != want.by) report("bitangent_y", got.by, want.by);
            if (got.bz != want.bz) report("bitangent_z", got.bz, want.bz);
            if (got.degen != want.degen) report("degenerate", got.degen, want.degen);
            if (got.last != want.last) report("last_corner", got.last, want.last);
         end
      end
   end

   // watchdog on a cycle counter
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LimitCyc) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // long receiver hold-off, counted here while the sender keeps offering
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HoldCyc) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic corner_type degenerate_corner(input int k);
      corner_type r;
      r = '0;
      r.corner = 2'(k); r.tx = tct_pkg::OneQ16; r.by = tct_pkg::OneQ16;
      r.degen = 1'b1; r.last = (k == 2);
      return r;
   endfunction

   row_type rows[$];

   task automatic add_row(input vertex_type v, input bit flat);
      row_type r;
      r.vtx = v;
      r.typed = flat;
      for (int k = 0; k < 3; k++) r.hand[k] = degenerate_corner(k);
      rows.insert(rows.size(), r);
   endtask

   initial begin
      corner_type want;
      vertex_type flat_v;
      eps_q = tct_pkg::EpsReset;
      vert_count = 0;
      for (int i = 0; i < 9; i++) pos_held[i] = 0;
      for (int i = 0; i < 6; i++) tex_held[i] = 0;
      flat_v = '{1, 2, 3, 7, 7};

      // directed table: extremes, flat UVs, exact unit mapping, saturation
      add_row('{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 18'sh1_FFFF, 18'sh2_0000}, 0);
      add_row('{32'sh8000_0000, 32'sh7FFF_FFFF, -1, 18'sh1_FFFF, 18'sh2_0000}, 0);
      // all UVs equal: zero determinant, defaults
      add_row('{1, 2, 3, 18'sh1_FFFF, 18'sh2_0000}, 1);
      add_row('{0, 0, 0, 0, 0}, 0);
      add_row('{32'sh1_0000, 0, 0, 18'sh1_0000, 0}, 0);
      add_row('{0, 32'sh1_0000, 0, 0, 18'sh1_0000}, 0);
      // tiny UV spread: det below the reset threshold
      add_row('{5, 6, 7, 0, 0}, 0);
      add_row('{-5, 60, 7, 1, 0}, 0);
      add_row('{9, -6, 70, 0, 1}, 1);
      // huge positions on a tiny UV triangle: saturation both ways
      add_row('{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0}, 0);
      add_row('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 18'sh100, 0}, 0);
      add_row('{0, 0, 32'sh8000_0000, 0, 18'sh100}, 0);
      // widest UV range, rounding toward zero
      add_row('{3, -7, 11, 18'sh2_0000, 18'sh2_0000}, 0);
      add_row('{-13, 17, -19, 18'sh1_FFFF, 18'sh2_0000}, 0);
      add_row('{23, 29, -31, 18'sh2_0000, 18'sh1_FFFF}, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_vertex(rows[i].vtx);
         if (rows[i].typed) begin
            // check the prediction tail against the hand-typed defaults
            for (int k = 0; k < 3; k++) begin
               want = pending_corners[pending_corners.size() - 3 + k];
               if (want != rows[i].hand[k]) report("directed row", i, k);
               pending_corners[pending_corners.size() - 3 + k] = rows[i].hand[k];
            end
         end
      end

      // threshold settings: zero still flags zero det, then the maximum
      write_epsilon(36'd0);
      for (int i = 0; i < 6; i++) begin
         if (i < 3) send_vertex(flat_v);
         else send_vertex(random_vertex());
      end
      write_epsilon(36'hF_FFFF_FFFF);
      for (int i = 0; i < 6; i++) send_vertex(random_vertex());
      write_epsilon(36'd1 << 20);

      // random triangles; pause once until drained at a triangle boundary
      for (int i = 0; i < ItemCount; i++) begin
         if (i == 3 * (ItemCount / 6)) write_epsilon(tct_pkg::EpsReset);
         if (i == ItemCount / 4) hold_go = 1'b1;
         if (i >= ItemCount - 30) calm = 1;
         send_vertex(random_vertex());
      end
      // close any open triangle so the vertex count returns to zero
      while (vert_count != 0) send_vertex(random_vertex());

      wait_drained();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### filelist.f
hdl/tct_pkg.sv
hdl/tct_div.sv
hdl/triangle_corner_tangent.sv
tb/triangle_corner_tangent_tb.sv
